[sv/seven_segment_display_command_encoder_assert.svh]
// ----------------------------------------------------------------------------
// Seven-segment display command encoder: assertion macros
// Shared concurrent-check macros, clocked on the rising edge and disabled
// while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_DISPLAY_COMMAND_ENCODER_ASSERT_SVH
`define SEVEN_SEGMENT_DISPLAY_COMMAND_ENCODER_ASSERT_SVH

// Same-cycle implication check
`define SSD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication check
`define SSD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ssd_pkg.sv]
// ----------------------------------------------------------------------------
// ssd_pkg
// Types, bus constants and the character table shared by the display
// command encoder modules.
// ----------------------------------------------------------------------------
package ssd_pkg;

    // Request opcodes
    localparam logic [2:0] OP_CHAR   = 3'd0;
    localparam logic [2:0] OP_NUM8   = 3'd1;
    localparam logic [2:0] OP_NUM12  = 3'd2;
    localparam logic [2:0] OP_NUM16  = 3'd3;
    localparam logic [2:0] OP_BRIGHT = 3'd4;
    localparam logic [2:0] OP_OFF    = 3'd5;
    localparam logic [2:0] OP_CLEAR  = 3'd6;
    localparam logic [2:0] OP_DP     = 3'd7;

    // Configuration register indexes
    localparam logic [2:0] REG_DIGIT_COUNT = 3'd0;
    localparam logic [2:0] REG_DUAL_DP     = 3'd1;
    localparam logic [2:0] REG_DIGIT_MAP   = 3'd2;
    localparam logic [2:0] REG_DP_ON       = 3'd3;
    localparam logic [2:0] REG_DP_OFF      = 3'd4;

    // Configuration reset values
    localparam logic [2:0] RST_DIGIT_COUNT = 3'd1;
    localparam logic       RST_DUAL_DP     = 1'b0;
    localparam logic [7:0] RST_DIGIT_MAP   = 8'd228;
    localparam logic [7:0] RST_DP_ON       = 8'd255;
    localparam logic [7:0] RST_DP_OFF      = 8'd0;

    // Bus bytes
    localparam logic [7:0] CMD_FIXED   = 8'h44;
    localparam logic [7:0] ADDR_BASE   = 8'hC0;
    localparam logic [7:0] BRIGHT_BASE = 8'h88;
    localparam logic [7:0] DISPLAY_OFF = 8'h80;
    localparam logic [7:0] RAW_MASK    = 8'h7f;
    localparam logic [7:0] BLANK_CODE  = 8'h00;

    // Digit holding the decimal points on a dual-point module
    localparam logic [1:0] DP_DIGIT = 2'd3;

    // Number clipping limits
    localparam logic [15:0] DEC_LIM2 = 16'd99;
    localparam logic [15:0] DEC_LIM3 = 16'd999;
    localparam logic [15:0] DEC_LIM4 = 16'd9999;
    localparam logic [15:0] HEX_LIM3 = 16'h0fff;

    // x / 10 == (x * RECIP10) >> 19 for every 16-bit x
    localparam logic [15:0] RECIP10     = 16'd52429;
    localparam int          RECIP_SHIFT = 19;

    // Character table
    localparam int         GLYPH_COUNT = 44;
    localparam logic [5:0] GLYPH_BLANK = 6'd32;
    localparam logic [7:0] GLYPHS [GLYPH_COUNT] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f,
        8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71,
        8'h58, 8'h6f, 8'h74, 8'h76, 8'h1e, 8'h38,
        8'h54, 8'h37, 8'h73, 8'h50, 8'h1c, 8'h3e, 8'h6e,
        8'h01, 8'h40, 8'h08, 8'h00, 8'h63, 8'h5c, 8'h46, 8'h70,
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40
    };

    // Segment code of a table index; out-of-range shows the blank character
    function automatic logic [7:0] glyph_code(input logic [7:0] idx);
        logic [7:0] code;
        if (idx < 8'(GLYPH_COUNT))
            code = GLYPHS[idx[5:0]];
        else
            code = GLYPHS[GLYPH_BLANK];
        return code;
    endfunction

    // Request item
    typedef struct packed {
        logic [2:0]  op;
        logic [1:0]  position;
        logic [15:0] value;
        logic        is_raw;
        logic        use_decimal;
        logic [2:0]  brightness_level;
        logic        dp_lit;
    } in_t;

    // Result item
    typedef struct packed {
        logic [7:0] bus_byte;
        logic       frame_start;
        logic       frame_end;
        logic       last;
    } out_t;

    // Effective configuration seen by front and back
    typedef struct packed {
        logic [2:0] cnt;
        logic       dual;
        logic [7:0] map;
        logic [7:0] dp_on;
        logic [7:0] dp_off;
    } cfg_view_t;

    typedef enum logic [1:0] {
        KIND_DIGITS,
        KIND_SINGLE,
        KIND_CLEAR,
        KIND_DP
    } kind_t;

    typedef enum logic [1:0] {
        CONV_NONE,
        CONV_DEC,
        CONV_HEX
    } conv_t;

    // Classified command passed from front to back
    typedef struct packed {
        kind_t       kind;
        conv_t       conv;
        logic [1:0]  pos;
        logic [1:0]  nlast;
        logic [15:0] value;
        logic [7:0]  code;
        logic [7:0]  single_byte;
        logic        dp_lit;
    } cmd_t;

endpackage

[sv/ssd_front.sv]
// ----------------------------------------------------------------------------
// ssd_front
// Accepts requests, clips positions and values, drops requests that send
// nothing, and queues classified commands for the sequencer (two entries).
// ----------------------------------------------------------------------------
module ssd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ssd_pkg::in_t      request,
    output logic              full,
    input  ssd_pkg::cfg_view_t cfg,
    input  logic              cmd_pop,
    output ssd_pkg::cmd_t     cmd,
    output logic              cmd_empty
);

    ssd_pkg::cmd_t cls;
    logic          keep;
    logic [2:0]    width;
    logic [2:0]    lim;
    logic [2:0]    cnt_m1;
    logic [15:0]   num;

    ssd_pkg::cmd_t mem_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    logic          wr_en;

    // Classify the request
    always_comb
    begin
        cls             = '0;
        cls.kind        = ssd_pkg::KIND_DIGITS;
        cls.conv        = ssd_pkg::CONV_NONE;
        cls.dp_lit      = request.dp_lit;
        keep            = 1'b1;
        cnt_m1          = cfg.cnt - 3'd1;
        width           = 3'd2;
        num             = request.value;

        case (request.op)
            ssd_pkg::OP_NUM8:  width = 3'd2;
            ssd_pkg::OP_NUM12: width = 3'd3;
            default:           width = 3'd4;
        endcase
        lim = cfg.cnt - width;

        case (request.op)
            ssd_pkg::OP_CHAR:
            begin
                cls.pos = ({1'b0, request.position} > cnt_m1) ? cnt_m1[1:0]
                                                              : request.position;
                if (request.is_raw)
                    cls.code = request.value[7:0] & ssd_pkg::RAW_MASK;
                else
                    cls.code = ssd_pkg::glyph_code(request.value[7:0]);
            end
            ssd_pkg::OP_NUM8, ssd_pkg::OP_NUM12, ssd_pkg::OP_NUM16:
            begin
                keep      = (cfg.cnt >= width);
                cls.pos   = ({1'b0, request.position} > lim) ? lim[1:0]
                                                             : request.position;
                cls.nlast = 2'(width - 3'd1);
                cls.conv  = request.use_decimal ? ssd_pkg::CONV_DEC : ssd_pkg::CONV_HEX;
                if (request.op == ssd_pkg::OP_NUM8)
                    num = {8'd0, request.value[7:0]};
                if (request.use_decimal)
                begin
                    if (request.op == ssd_pkg::OP_NUM8 && num > ssd_pkg::DEC_LIM2)
                        num = ssd_pkg::DEC_LIM2;
                    else if (request.op == ssd_pkg::OP_NUM12 && num > ssd_pkg::DEC_LIM3)
                        num = ssd_pkg::DEC_LIM3;
                    else if (request.op == ssd_pkg::OP_NUM16 && num > ssd_pkg::DEC_LIM4)
                        num = ssd_pkg::DEC_LIM4;
                end
                else if (request.op == ssd_pkg::OP_NUM12 && num > ssd_pkg::HEX_LIM3)
                begin
                    num = ssd_pkg::HEX_LIM3;
                end
                cls.value = num;
            end
            ssd_pkg::OP_BRIGHT:
            begin
                cls.kind        = ssd_pkg::KIND_SINGLE;
                cls.single_byte = ssd_pkg::BRIGHT_BASE + {5'd0, request.brightness_level};
            end
            ssd_pkg::OP_OFF:
            begin
                cls.kind        = ssd_pkg::KIND_SINGLE;
                cls.single_byte = ssd_pkg::DISPLAY_OFF;
            end
            ssd_pkg::OP_CLEAR:
            begin
                cls.kind = ssd_pkg::KIND_CLEAR;
            end
            default:
            begin
                // decimal point op: only a dual-point module sends anything
                cls.kind = ssd_pkg::KIND_DP;
                keep     = cfg.dual;
            end
        endcase
    end

    // Command queue
    assign full      = (count_reg == 2'd2);
    assign cmd_empty = (count_reg == 2'd0);
    assign cmd       = mem_reg[rd_ptr_reg];
    assign wr_en     = push && !full && keep;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ cmd_pop;
        count_next  = count_reg + {1'b0, wr_en} - {1'b0, cmd_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= cls;
    end

endmodule

[sv/ssd_back.sv]
// ----------------------------------------------------------------------------
// ssd_back
// Sequencer: converts numbers to digit codes one digit a cycle, holds the
// digit codes, and emits the command, address, segment and single bytes.
// ----------------------------------------------------------------------------
module ssd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  ssd_pkg::cfg_view_t cfg,
    input  ssd_pkg::cmd_t      cmd,
    input  logic               cmd_empty,
    output logic               cmd_pop,
    output logic               emit_valid,
    output ssd_pkg::out_t      emit,
    input  logic               out_full
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_CMD,
        S_ADDR,
        S_DATA,
        S_SINGLE
    } state_t;

    state_t        state_reg, state_next;
    ssd_pkg::cmd_t cur_reg, cur_next;
    logic [1:0]    dig_reg, dig_next;
    logic [1:0]    left_reg, left_next;
    logic [15:0]   val_reg, val_next;
    logic [1:0]    cidx_reg, cidx_next;
    logic [1:0]    cleft_reg, cleft_next;
    logic          dpph_reg, dpph_next;
    logic [7:0]    codes_reg [4];
    logic [7:0]    codes_next [4];

    logic          adv;
    logic          tail;
    logic [31:0]   prod;
    logic [15:0]   quot;
    logic [15:0]   rem16;
    logic [3:0]    digit;
    logic [7:0]    map_sh;
    logic [7:0]    addr;

    // Digit extraction: divide by ten through the reciprocal
    assign prod  = 32'(val_reg) * 32'(ssd_pkg::RECIP10);
    assign quot  = 16'(prod >> ssd_pkg::RECIP_SHIFT);
    assign rem16 = val_reg - ((quot << 3) + (quot << 1));
    assign digit = (cur_reg.conv == ssd_pkg::CONV_DEC) ? rem16[3:0] : val_reg[3:0];

    // Address byte through the digit map
    assign map_sh = cfg.map >> {dig_reg, 1'b0};
    assign addr   = (cfg.dual && dig_reg == ssd_pkg::DP_DIGIT)
                  ? {ssd_pkg::ADDR_BASE[7:2], ssd_pkg::DP_DIGIT}
                  : {ssd_pkg::ADDR_BASE[7:2], map_sh[1:0]};

    // Clear is followed by the dark decimal point frame on dual-point modules
    assign tail = (cur_reg.kind == ssd_pkg::KIND_CLEAR) && cfg.dual && !dpph_reg;

    // Byte output
    always_comb
    begin
        emit_valid = 1'b1;
        emit       = '0;
        case (state_reg)
            S_CMD:
            begin
                emit.bus_byte    = ssd_pkg::CMD_FIXED;
                emit.frame_start = 1'b1;
                emit.frame_end   = 1'b1;
            end
            S_ADDR:
            begin
                emit.bus_byte    = addr;
                emit.frame_start = 1'b1;
            end
            S_DATA:
            begin
                emit.bus_byte  = codes_reg[dig_reg];
                emit.frame_end = 1'b1;
                emit.last      = (left_reg == 2'd0) && !tail;
            end
            S_SINGLE:
            begin
                emit.bus_byte    = cur_reg.single_byte;
                emit.frame_start = 1'b1;
                emit.frame_end   = 1'b1;
                emit.last        = 1'b1;
            end
            default:
            begin
                emit_valid = 1'b0;
            end
        endcase
    end

    assign adv = emit_valid && !out_full;

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        dig_next   = dig_reg;
        left_next  = left_reg;
        val_next   = val_reg;
        cidx_next  = cidx_reg;
        cleft_next = cleft_reg;
        dpph_next  = dpph_reg;
        codes_next = codes_reg;
        cmd_pop    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop   = 1'b1;
                    cur_next  = cmd;
                    dpph_next = 1'b0;
                    dig_next  = cmd.pos;
                    left_next = cmd.nlast;
                    case (cmd.kind)
                        ssd_pkg::KIND_DIGITS:
                        begin
                            if (cmd.conv == ssd_pkg::CONV_NONE)
                            begin
                                codes_next[cmd.pos] = cmd.code;
                                state_next          = S_CMD;
                            end
                            else
                            begin
                                val_next   = cmd.value;
                                cidx_next  = cmd.pos + cmd.nlast;
                                cleft_next = cmd.nlast;
                                state_next = S_CONV;
                            end
                        end
                        ssd_pkg::KIND_SINGLE:
                        begin
                            state_next = S_SINGLE;
                        end
                        ssd_pkg::KIND_CLEAR:
                        begin
                            dig_next      = 2'd0;
                            left_next     = 2'(cfg.cnt - 3'd1);
                            codes_next[0] = ssd_pkg::BLANK_CODE;
                            state_next    = S_CMD;
                        end
                        default:
                        begin
                            dig_next   = ssd_pkg::DP_DIGIT;
                            left_next  = 2'd0;
                            codes_next[ssd_pkg::DP_DIGIT] = cmd.dp_lit ? cfg.dp_on
                                                                       : cfg.dp_off;
                            state_next = S_CMD;
                        end
                    endcase
                end
            end
            S_CONV:
            begin
                // least significant digit first, rightmost position first
                codes_next[cidx_reg] = ssd_pkg::glyph_code({4'd0, digit});
                val_next   = (cur_reg.conv == ssd_pkg::CONV_DEC) ? quot : (val_reg >> 4);
                cidx_next  = cidx_reg - 2'd1;
                cleft_next = cleft_reg - 2'd1;
                if (cleft_reg == 2'd0)
                    state_next = S_CMD;
            end
            S_CMD:
            begin
                if (adv)
                    state_next = S_ADDR;
            end
            S_ADDR:
            begin
                if (adv)
                    state_next = S_DATA;
            end
            S_DATA:
            begin
                if (adv)
                begin
                    if (left_reg != 2'd0)
                    begin
                        dig_next  = dig_reg + 2'd1;
                        left_next = left_reg - 2'd1;
                        if (cur_reg.kind == ssd_pkg::KIND_CLEAR)
                        begin
                            codes_next[dig_reg + 2'd1] = ssd_pkg::BLANK_CODE;
                            state_next = S_CMD;
                        end
                        else
                        begin
                            state_next = S_ADDR;
                        end
                    end
                    else if (tail)
                    begin
                        dpph_next  = 1'b1;
                        dig_next   = ssd_pkg::DP_DIGIT;
                        codes_next[ssd_pkg::DP_DIGIT] = cfg.dp_off;
                        state_next = S_CMD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_SINGLE:
            begin
                if (adv)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            dpph_reg  <= 1'b0;
            for (int i = 0; i < 4; i++)
                codes_reg[i] <= ssd_pkg::BLANK_CODE;
        end
        else
        begin
            state_reg <= state_next;
            dpph_reg  <= dpph_next;
            codes_reg <= codes_next;
        end
    end

    // Working payload
    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        dig_reg   <= dig_next;
        left_reg  <= left_next;
        val_reg   <= val_next;
        cidx_reg  <= cidx_next;
        cleft_reg <= cleft_next;
    end

endmodule

[sv/ssd_outq.sv]
// ----------------------------------------------------------------------------
// ssd_outq
// Two-entry result queue between the sequencer and the result port.
// ----------------------------------------------------------------------------
module ssd_outq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  ssd_pkg::out_t din,
    output logic          full,
    input  logic          pop,
    output ssd_pkg::out_t dout,
    output logic          empty
);

    ssd_pkg::out_t mem_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    logic          push_ok;
    logic          pop_ok;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign dout    = mem_reg[rd_ptr_reg];
    assign push_ok = wr_en && !full;
    assign pop_ok  = pop && !empty;

    // Pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push_ok;
        rd_ptr_next = rd_ptr_reg ^ pop_ok;
        count_next  = count_reg + {1'b0, push_ok} - {1'b0, pop_ok};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push_ok)
            mem_reg[wr_ptr_reg] <= din;
    end

endmodule

[sv/seven_segment_display_command_encoder.sv]
// A request passes through the command queue, the sequencer and the result queue
// before its first byte is on the result port; number requests are first turned
// into digit codes. The sequencer sends one byte a cycle while the result queue
// is not full, and takes a new command only after the last byte of the current one.
// Reset: configuration returns to its defaults, digit codes to blank, queues empty.
// ----------------------------------------------------------------------------
// seven_segment_display_command_encoder
// Turns display requests into bus byte frames for a 4-digit LED driver.
// ----------------------------------------------------------------------------
`include "seven_segment_display_command_encoder_assert.svh"

module seven_segment_display_command_encoder #(
    parameter int NUM_DIGITS = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ssd_pkg::in_t  request,
    output logic          full,
    input  logic          pop,
    output ssd_pkg::out_t result,
    output logic          empty,
    input  logic          wr_en,
    input  logic [2:0]    wr_index,
    input  logic [7:0]    wr_data
);

    logic [2:0] digit_count_reg;
    logic       dual_dp_reg;
    logic [7:0] digit_map_reg;
    logic [7:0] dp_on_reg;
    logic [7:0] dp_off_reg;

    ssd_pkg::cfg_view_t cfg;
    ssd_pkg::cmd_t      cmd;
    logic               cmd_empty;
    logic               cmd_pop;
    logic               emit_valid;
    ssd_pkg::out_t      emit;
    logic               out_full;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_count_reg <= ssd_pkg::RST_DIGIT_COUNT;
            dual_dp_reg     <= ssd_pkg::RST_DUAL_DP;
            digit_map_reg   <= ssd_pkg::RST_DIGIT_MAP;
            dp_on_reg       <= ssd_pkg::RST_DP_ON;
            dp_off_reg      <= ssd_pkg::RST_DP_OFF;
        end
        else if (wr_en)
        begin
            case (wr_index)
                ssd_pkg::REG_DIGIT_COUNT: digit_count_reg <= wr_data[2:0];
                ssd_pkg::REG_DUAL_DP:     dual_dp_reg     <= wr_data[0];
                ssd_pkg::REG_DIGIT_MAP:   digit_map_reg   <= wr_data;
                ssd_pkg::REG_DP_ON:       dp_on_reg       <= wr_data;
                ssd_pkg::REG_DP_OFF:      dp_off_reg      <= wr_data;
                default:                  ;
            endcase
        end
    end

    // Effective configuration: out-of-range digit count acts as one digit
    always_comb
    begin
        if (digit_count_reg >= 3'd1 && digit_count_reg <= 3'(NUM_DIGITS))
            cfg.cnt = digit_count_reg;
        else
            cfg.cnt = 3'd1;
        cfg.dual   = dual_dp_reg && (cfg.cnt == 3'd3);
        cfg.map    = digit_map_reg;
        cfg.dp_on  = dp_on_reg;
        cfg.dp_off = dp_off_reg;
    end

    ssd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .request   (request),
        .full      (full),
        .cfg       (cfg),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .cmd_empty (cmd_empty)
    );

    ssd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd        (cmd),
        .cmd_empty  (cmd_empty),
        .cmd_pop    (cmd_pop),
        .emit_valid (emit_valid),
        .emit       (emit),
        .out_full   (out_full)
    );

    ssd_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (emit_valid),
        .din   (emit),
        .full  (out_full),
        .pop   (pop),
        .dout  (result),
        .empty (empty)
    );

    // Checks
    `SSD_ASSERT_IMP(a_pop_nonempty, clk, rst_n, cmd_pop, !cmd_empty, "command pop on empty queue")
    `SSD_ASSERT_IMP(a_data_closes, clk, rst_n, !empty && !result.frame_start, result.frame_end, "segment byte without stop")
    `SSD_ASSERT_IMP(a_last_closes, clk, rst_n, !empty && result.last, result.frame_end, "final byte without stop")
    `SSD_ASSERT_NXT(a_pop_leaves_idle, clk, rst_n, cmd_pop, !cmd_pop, "back-to-back command pops")

endmodule
